// ----- sv/rfa_pkg.sv -----
// ----------------------------------------------------------------------------
// rfa_pkg: shared types and codes for the range follow/avoid controller
// Item and result layouts, state and configuration records, command, action
// and phase codes, and the range-to-centimetre conversion.
// ----------------------------------------------------------------------------
package rfa_pkg;

    // Drive actions
    localparam logic [2:0] ACT_NONE  = 3'd0;
    localparam logic [2:0] ACT_STOP  = 3'd1;
    localparam logic [2:0] ACT_FWD   = 3'd2;
    localparam logic [2:0] ACT_BACK  = 3'd3;
    localparam logic [2:0] ACT_LEFT  = 3'd4;
    localparam logic [2:0] ACT_RIGHT = 3'd5;
    localparam logic [2:0] ACT_HOLD  = 3'd6;

    // Command codes
    localparam logic [3:0] CMD_FWD       = 4'd0;
    localparam logic [3:0] CMD_BACK      = 4'd1;
    localparam logic [3:0] CMD_LEFT      = 4'd2;
    localparam logic [3:0] CMD_RIGHT     = 4'd3;
    localparam logic [3:0] CMD_STOP      = 4'd4;
    localparam logic [3:0] CMD_STOP_ZERO = 4'd5;
    localparam logic [3:0] CMD_SET_SPEED = 4'd6;
    localparam logic [3:0] CMD_UP        = 4'd7;
    localparam logic [3:0] CMD_DOWN      = 4'd8;
    localparam logic [3:0] CMD_FOLLOW    = 4'd9;

    // Item kinds
    localparam logic KIND_SAMPLE  = 1'b0;
    localparam logic KIND_COMMAND = 1'b1;

    // Reported mode
    localparam logic [1:0] MODE_NONE   = 2'd0;
    localparam logic [1:0] MODE_AVOID  = 2'd1;
    localparam logic [1:0] MODE_FOLLOW = 2'd2;

    // Follower phases
    localparam logic [2:0] PHASE_NONE        = 3'd0;
    localparam logic [2:0] PHASE_NEAR        = 3'd1;
    localparam logic [2:0] PHASE_FAR         = 3'd2;
    localparam logic [2:0] PHASE_LOST_LEFT   = 3'd3;
    localparam logic [2:0] PHASE_LOST_AHEAD  = 3'd4;
    localparam logic [2:0] PHASE_LOST_RIGHT  = 3'd5;

    // Target sides
    localparam logic [1:0] SIDE_UNKNOWN = 2'd0;
    localparam logic [1:0] SIDE_LEFT    = 2'd1;
    localparam logic [1:0] SIDE_AHEAD   = 2'd2;
    localparam logic [1:0] SIDE_RIGHT   = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] REG_FOLLOW_NEAR = 3'd0;
    localparam logic [2:0] REG_FOLLOW_FAR  = 3'd1;
    localparam logic [2:0] REG_AVOID_SLOW  = 3'd2;
    localparam logic [2:0] REG_AVOID_FAST  = 3'd3;
    localparam logic [2:0] REG_SPEED_SW    = 3'd4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    // Configuration reset values
    localparam logic [7:0] FOLLOW_NEAR_RST = 8'd15;
    localparam logic [7:0] FOLLOW_FAR_RST  = 8'd50;
    localparam logic [7:0] AVOID_SLOW_RST  = 8'd15;
    localparam logic [7:0] AVOID_FAST_RST  = 8'd50;
    localparam logic [6:0] SPEED_SW_RST    = 7'd80;

    // Speed limits
    localparam logic signed [7:0] SPEED_MAX  = 8'sd100;
    localparam logic signed [7:0] SPEED_MIN  = -8'sd100;
    localparam logic signed [8:0] SPEED_WRAP_HI = 9'sd101;
    localparam logic signed [8:0] SPEED_WRAP_LO = -9'sd101;

    // Divide by 100: ceil(2^23 / 100) keeps the error below one count for 16-bit input
    localparam int          RECIP_SHIFT = 23;
    localparam logic [16:0] RECIP_100   = 17'd83887;

    typedef struct packed {
        logic               kind;
        logic [15:0]        left_range;
        logic [15:0]        right_range;
        logic [3:0]         command_code;
        logic signed [7:0]  speed_value;
        logic               is_repeat;
    } item_t;

    typedef struct packed {
        logic [2:0]         drive_action;
        logic               capture_heading;
        logic signed [7:0]  speed_now;
        logic [1:0]         mode_now;
        logic [2:0]         follow_phase;
        logic [1:0]         target_side;
    } result_t;

    typedef struct packed {
        logic signed [7:0]  speed;
        logic               avoid_on;
        logic               follow_on;
        logic [2:0]         phase;
        logic [1:0]         side;
        logic               heading_latched;
        logic               fast_threshold;
    } state_t;

    typedef struct packed {
        logic [7:0] follow_near_cm;
        logic [7:0] follow_far_cm;
        logic [7:0] avoid_slow_cm;
        logic [7:0] avoid_fast_cm;
        logic [6:0] speed_switch;
    } cfg_t;

    // Range in 1/100 cm to whole centimetres, truncated (0..655)
    function automatic logic [9:0] range_to_cm(input logic [15:0] range);
        logic [32:0] prod;
        prod = 33'(range) * 33'(RECIP_100);
        return prod[RECIP_SHIFT +: 10];
    endfunction

endpackage

// ----- sv/rfa_item_if.sv -----
// ----------------------------------------------------------------------------
// rfa_item_if: input item channel
// Valid/ready channel carrying one command or distance sample.
// ----------------------------------------------------------------------------
interface rfa_item_if
    import rfa_pkg::*;
    ;
    logic  valid;
    logic  ready;
    item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- sv/rfa_result_if.sv -----
// ----------------------------------------------------------------------------
// rfa_result_if: result channel
// Valid/ready channel carrying one drive action with status.
// ----------------------------------------------------------------------------
interface rfa_result_if
    import rfa_pkg::*;
    ;
    logic    valid;
    logic    ready;
    result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- sv/rfa_core.sv -----
// ----------------------------------------------------------------------------
// rfa_core: decision logic for one item
// Computes the next controller state and the result from the registered item.
// ----------------------------------------------------------------------------
module rfa_core
    import rfa_pkg::*;
(
    input  item_t   item,
    input  state_t  state,
    input  cfg_t    cfg,
    output state_t  state_next,
    output result_t result
);

    logic [9:0]        l_cm;
    logic [9:0]        r_cm;
    logic [9:0]        near_cm;
    logic [9:0]        far_cm;
    logic [9:0]        thr_cm;
    logic signed [8:0] speed_step;
    logic              cap;
    logic [2:0]        act;
    state_t            s;

    assign l_cm    = range_to_cm(item.left_range);
    assign r_cm    = range_to_cm(item.right_range);
    assign near_cm = 10'(cfg.follow_near_cm);
    assign far_cm  = 10'(cfg.follow_far_cm);
    assign thr_cm  = state.fast_threshold ? 10'(cfg.avoid_fast_cm) : 10'(cfg.avoid_slow_cm);

    always_comb
    begin
        s   = state;
        act = ACT_NONE;
        cap = 1'b0;
        speed_step = {state.speed[7], state.speed};

        // Release the heading when no mode is on
        if (!s.avoid_on && !s.follow_on)
        begin
            s.heading_latched = 1'b0;
        end

        if (item.kind == KIND_COMMAND)
        begin
            unique case (item.command_code) inside
                CMD_FWD:
                begin
                    s.follow_on = 1'b0;
                    s.avoid_on  = 1'b1;
                    act         = ACT_FWD;
                end
                CMD_BACK, CMD_LEFT, CMD_RIGHT, CMD_STOP, CMD_STOP_ZERO:
                begin
                    s.follow_on = 1'b0;
                    s.avoid_on  = 1'b0;
                    case (item.command_code)
                        CMD_BACK:  act = ACT_BACK;
                        CMD_LEFT:  act = ACT_LEFT;
                        CMD_RIGHT: act = ACT_RIGHT;
                        default:   act = ACT_STOP;
                    endcase
                    if (item.command_code == CMD_STOP_ZERO)
                    begin
                        speed_step = '0;
                    end
                end
                CMD_SET_SPEED:
                begin
                    if (item.speed_value > SPEED_MAX)
                        speed_step = {SPEED_MAX[7], SPEED_MAX};
                    else if (item.speed_value < SPEED_MIN)
                        speed_step = {SPEED_MIN[7], SPEED_MIN};
                    else
                        speed_step = {item.speed_value[7], item.speed_value};
                end
                CMD_UP:   speed_step = {state.speed[7], state.speed} + 9'sd1;
                CMD_DOWN: speed_step = {state.speed[7], state.speed} - 9'sd1;
                CMD_FOLLOW:
                begin
                    if (!item.is_repeat)
                    begin
                        s.follow_on = !s.follow_on;
                        s.avoid_on  = 1'b0;
                        s.phase     = PHASE_NONE;
                        s.side      = SIDE_UNKNOWN;
                        act         = ACT_STOP;
                    end
                end
                default: ;
            endcase

            // Wrap a speed stepped past the limit back to zero
            if (speed_step == SPEED_WRAP_HI || speed_step == SPEED_WRAP_LO)
                s.speed = '0;
            else
                s.speed = speed_step[7:0];

            s.fast_threshold = !s.speed[7] && (s.speed[6:0] > cfg.speed_switch);
        end
        else if (s.avoid_on)
        begin
            if (l_cm < thr_cm && r_cm > thr_cm)
            begin
                s.heading_latched = 1'b0;
                act = ACT_RIGHT;
            end
            else if (l_cm > thr_cm && r_cm < thr_cm)
            begin
                s.heading_latched = 1'b0;
                act = ACT_LEFT;
            end
            else if (l_cm > thr_cm && r_cm > thr_cm)
            begin
                if (!s.heading_latched)
                begin
                    s.heading_latched = 1'b1;
                    cap = 1'b1;
                end
                act = (s.speed > 8'sd0) ? ACT_HOLD : ACT_NONE;
            end
            else if (l_cm < thr_cm && r_cm < thr_cm)
            begin
                s.heading_latched = 1'b0;
                act = ACT_RIGHT;
            end
        end
        else if (s.follow_on)
        begin
            // Action follows the phase held before this sample
            case (state.phase) inside
                PHASE_NONE, PHASE_NEAR:       act = ACT_STOP;
                PHASE_FAR, PHASE_LOST_AHEAD:  act = ACT_FWD;
                PHASE_LOST_LEFT:              act = ACT_LEFT;
                PHASE_LOST_RIGHT:             act = ACT_RIGHT;
                default:                      act = ACT_NONE;
            endcase

            if (state.phase <= PHASE_LOST_RIGHT)
            begin
                if (l_cm < near_cm && r_cm > near_cm)
                begin
                    s.phase = PHASE_NEAR; s.side = SIDE_LEFT;
                end
                else if (l_cm < near_cm && r_cm < near_cm)
                begin
                    s.phase = PHASE_NEAR; s.side = SIDE_AHEAD;
                end
                else if (l_cm > near_cm && r_cm < near_cm)
                begin
                    s.phase = PHASE_NEAR; s.side = SIDE_RIGHT;
                end
                else if (l_cm > near_cm && l_cm < far_cm && r_cm > far_cm)
                begin
                    s.phase = PHASE_FAR; s.side = SIDE_LEFT;
                end
                else if (l_cm > near_cm && l_cm < far_cm && r_cm > near_cm && r_cm < far_cm)
                begin
                    s.phase = PHASE_FAR; s.side = SIDE_AHEAD;
                end
                else if (l_cm > far_cm && r_cm > near_cm && r_cm < far_cm)
                begin
                    s.phase = PHASE_FAR; s.side = SIDE_RIGHT;
                end
                else if (l_cm > far_cm && r_cm > far_cm)
                begin
                    if (state.phase == PHASE_NONE)
                        s.side = SIDE_UNKNOWN;
                    else if ((state.phase == PHASE_NEAR || state.phase == PHASE_FAR)
                             && state.side != SIDE_UNKNOWN)
                        s.phase = 3'(state.side) + 3'd2;
                end
            end
        end
    end

    assign state_next = s;

    always_comb
    begin
        result.drive_action    = act;
        result.capture_heading = cap;
        result.speed_now       = s.speed;
        result.mode_now        = s.avoid_on ? MODE_AVOID : (s.follow_on ? MODE_FOLLOW : MODE_NONE);
        result.follow_phase    = s.phase;
        result.target_side     = s.side;
    end

endmodule

// ----- sv/range_follow_avoid_controller.sv -----
// ----------------------------------------------------------------------------
// range_follow_avoid_controller: drive-mode controller for two range sensors
// Commands set speed and mode; samples steer in avoid mode or track a target
// in follow mode. One result per item.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle on the item channel while
// the result channel is not stalled, and returns exactly one result for
// each, in order, from the result register. An item first lands in an
// input register; from there a single pass of decision logic (one
// 16x17 reciprocal multiply per sensor for the divide by 100, then compares
// and selection) updates the controller state and loads the result register.
// Back-pressure on the result channel holds the result register, then the
// input register, and only then drops ready on the item channel, so a full
// pipeline keeps moving at one transaction per cycle while results are taken.
// Configuration writes take effect on the next clock edge and should be made
// while no transaction is in flight.
module range_follow_avoid_controller
    import rfa_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    rfa_item_if.sink               item,
    rfa_result_if.source           result
);

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    logic    in_valid_reg;
    item_t   in_data_reg;
    logic    out_valid_reg;
    result_t out_data_reg;
    result_t out_data_next;
    logic    advance;

    // Result stage can load when empty or when its transaction leaves now
    assign advance    = !out_valid_reg || result.ready;
    assign item.ready = !in_valid_reg || advance;

    assign result.valid   = out_valid_reg;
    assign result.payload = out_data_reg;

    // Configuration registers: write by index, ignore unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.follow_near_cm <= FOLLOW_NEAR_RST;
            cfg_reg.follow_far_cm  <= FOLLOW_FAR_RST;
            cfg_reg.avoid_slow_cm  <= AVOID_SLOW_RST;
            cfg_reg.avoid_fast_cm  <= AVOID_FAST_RST;
            cfg_reg.speed_switch   <= SPEED_SW_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_FOLLOW_NEAR: cfg_reg.follow_near_cm <= cfg_wr_data;
                REG_FOLLOW_FAR:  cfg_reg.follow_far_cm  <= cfg_wr_data;
                REG_AVOID_SLOW:  cfg_reg.avoid_slow_cm  <= cfg_wr_data;
                REG_AVOID_FAST:  cfg_reg.avoid_fast_cm  <= cfg_wr_data;
                REG_SPEED_SW:    cfg_reg.speed_switch   <= cfg_wr_data[6:0];
                default: ;
            endcase
        end
    end

    // Input stage: capture a transaction whenever there is room
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            in_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
        begin
            in_data_reg <= item.payload;
        end
    end

    rfa_core u_core (
        .item       (in_data_reg),
        .state      (state_reg),
        .cfg        (cfg_reg),
        .state_next (state_next),
        .result     (out_data_next)
    );

    // Controller state advances only when the item moves into the result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

`ifndef SYNTHESIS
    // A heading capture only comes from avoid mode
    a_capture_in_avoid: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.payload.capture_heading)
            |-> (result.payload.mode_now == MODE_AVOID))
        else $error("heading capture outside avoid mode");

    // Reported speed stays inside the legal range
    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.payload.speed_now <= SPEED_MAX
                          && result.payload.speed_now >= SPEED_MIN))
        else $error("speed out of range");

    // A held item moves into the result stage when that stage is free
    a_item_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && advance) |=> result.valid)
        else $error("held item did not reach the result stage");
`endif

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: range follow/avoid controller check
// Drives commands and distance samples through the item channel with random
// idle and stall bursts, predicts every drive result in step with the block,
// and compares each result transaction field by field against the oldest
// prediction. Thresholds and the speed switch are changed between phases.
// ----------------------------------------------------------------------------
module testbench;
    import rfa_pkg::*;

    // Codes above the follow toggle carry no meaning; the top one marks the
    // end of the unknown range.
    localparam logic [3:0] CMD_UNKNOWN_TOP = 4'd15;

    localparam int DIR_N      = 30;
    localparam int PHASES     = 6;
    localparam int PHASE_ITEMS = 120;

    // One row of the directed table. A pinned row carries its own expected
    // action, speed and mode (phase, side and capture are zero on those rows);
    // every other row is checked against the predictor.
    typedef struct packed {
        logic              kind;
        logic [15:0]       l_range;
        logic [15:0]       r_range;
        logic [3:0]        code;
        logic signed [7:0] sval;
        logic              rep;
        logic              pin;
        logic [2:0]        act;
        logic signed [7:0] spd;
        logic [1:0]        mode;
    } stim_row_t;

    // Directed part: runs under the reset thresholds (near 15, far 50,
    // slow 15, fast 50, switch 80).
    localparam stim_row_t DIR_ROWS [DIR_N] = '{
        // no mode yet: sample does nothing
        '{KIND_SAMPLE, 0, 0, CMD_FWD, 0, 0, 1, ACT_NONE, 0, MODE_NONE},
        // set speed saturates high, up from 100 wraps to zero
        '{KIND_COMMAND, 0, 0, CMD_SET_SPEED, 127, 0, 1, ACT_NONE, 100, MODE_NONE},
        '{KIND_COMMAND, 0, 0, CMD_UP, 0, 0, 1, ACT_NONE, 0, MODE_NONE},
        // set speed saturates low, down from -100 wraps to zero
        '{KIND_COMMAND, 0, 0, CMD_SET_SPEED, -128, 0, 1, ACT_NONE, -100, MODE_NONE},
        '{KIND_COMMAND, 0, 0, CMD_DOWN, 0, 0, 1, ACT_NONE, 0, MODE_NONE},
        '{KIND_COMMAND, 0, 0, CMD_SET_SPEED, 101, 0, 0, ACT_NONE, 0, MODE_NONE},
        '{KIND_COMMAND, 0, 0, CMD_SET_SPEED, -101, 0, 0, ACT_NONE, 0, MODE_NONE},
        // above the switch: fast threshold (50 cm)
        '{KIND_COMMAND, 0, 0, CMD_SET_SPEED, 90, 0, 0, ACT_NONE, 0, MODE_NONE},
        '{KIND_COMMAND, 0, 0, CMD_FWD, 0, 0, 0, ACT_NONE, 0, MODE_NONE},
        // both clear: capture heading and hold
        '{KIND_SAMPLE, 6000, 10000, CMD_FWD, -1, 1, 0, ACT_NONE, 0, MODE_NONE},
        '{KIND_SAMPLE, 1000, 10000, CMD_FWD, -1, 1, 0, ACT_NONE, 0, MODE_NONE},
        '{KIND_SAMPLE, 10000, 1000, CMD_FWD, -1, 1, 0, ACT_NONE, 0, MODE_NONE},
        '{KIND_SAMPLE, 1000, 1000, CMD_FWD, -1, 1, 0, ACT_NONE, 0, MODE_NONE},
        // left exactly on the threshold: no branch
        '{KIND_SAMPLE, 5000, 9000, CMD_FWD, -1, 1, 0, ACT_NONE, 0, MODE_NONE},
        '{KIND_COMMAND, 0, 0, CMD_UNKNOWN_TOP, 0, 0, 0, ACT_NONE, 0, MODE_NONE},
        // held-key toggle is ignored, a fresh one enters follow
        '{KIND_COMMAND, 0, 0, CMD_FOLLOW, 0, 1, 0, ACT_NONE, 0, MODE_NONE},
        '{KIND_COMMAND, 0, 0, CMD_FOLLOW, 0, 0, 0, ACT_NONE, 0, MODE_NONE},
        // walk the follower: lost from none, far ahead, lost ahead, near left,
        // lost left, then an on-the-limit sample that keeps the phase
        '{KIND_SAMPLE, 6000, 6000, CMD_FWD, -1, 1, 0, ACT_NONE, 0, MODE_NONE},
        '{KIND_SAMPLE, 3000, 3000, CMD_FWD, -1, 1, 0, ACT_NONE, 0, MODE_NONE},
        '{KIND_SAMPLE, 6000, 6000, CMD_FWD, -1, 1, 0, ACT_NONE, 0, MODE_NONE},
        '{KIND_SAMPLE, 1000, 3000, CMD_FWD, -1, 1, 0, ACT_NONE, 0, MODE_NONE},
        '{KIND_SAMPLE, 6000, 6000, CMD_FWD, -1, 1, 0, ACT_NONE, 0, MODE_NONE},
        '{KIND_SAMPLE, 1500, 1500, CMD_FWD, -1, 1, 0, ACT_NONE, 0, MODE_NONE},
        // stop with zero speed, back to avoid: capture at speed zero gives none
        '{KIND_COMMAND, 0, 0, CMD_STOP_ZERO, 0, 0, 0, ACT_NONE, 0, MODE_NONE},
        '{KIND_COMMAND, 0, 0, CMD_FWD, 0, 0, 0, ACT_NONE, 0, MODE_NONE},
        '{KIND_SAMPLE, 65535, 65535, CMD_FWD, -1, 1, 0, ACT_NONE, 0, MODE_NONE},
        '{KIND_COMMAND, 0, 0, CMD_BACK, 0, 0, 0, ACT_NONE, 0, MODE_NONE},
        '{KIND_COMMAND, 0, 0, CMD_LEFT, 0, 0, 0, ACT_NONE, 0, MODE_NONE},
        '{KIND_COMMAND, 0, 0, CMD_RIGHT, 0, 0, 0, ACT_NONE, 0, MODE_NONE},
        '{KIND_COMMAND, 0, 0, CMD_STOP, 0, 0, 0, ACT_NONE, 0, MODE_NONE}
    };

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wr_data;

    rfa_item_if   item_ch ();
    rfa_result_if result_ch ();

    range_follow_avoid_controller u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .item        (item_ch),
        .result      (result_ch)
    );

    // Controller state as the predictor sees it, starting from reset.
    int         speed_cur    = 0;
    bit         avoid_mode   = 1'b0;
    bit         follow_mode  = 1'b0;
    bit         heading_held = 1'b0;
    bit         fast_sel     = 1'b0;
    logic [2:0] phase_cur    = PHASE_NONE;
    logic [1:0] side_cur     = SIDE_UNKNOWN;
    cfg_t       cfg_cur      = '{FOLLOW_NEAR_RST, FOLLOW_FAR_RST, AVOID_SLOW_RST,
                                 AVOID_FAST_RST, SPEED_SW_RST};

    result_t expected_drive_q [$];
    int      items_taken    = 0;
    int      mismatch_count = 0;
    logic    pinned_now;
    result_t pinned_result;
    logic    quiet_tail;
    result_t predicted;
    result_t want;
    result_t got;

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Advance the predicted state by one item and return the drive result.
    function automatic result_t next_drive_result(input item_t it);
        result_t    res;
        logic [2:0] act;
        logic       cap;
        int         spd;
        int         l;
        int         r;
        int         n;
        int         f;
        int         thr;
        act = ACT_NONE;
        cap = 1'b0;
        if (!avoid_mode && !follow_mode)
            heading_held = 1'b0;
        if (it.kind == KIND_COMMAND)
        begin
            spd = speed_cur;
            case (it.command_code)
                CMD_FWD:
                begin
                    follow_mode = 1'b0;
                    avoid_mode  = 1'b1;
                    act         = ACT_FWD;
                end
                CMD_BACK, CMD_LEFT, CMD_RIGHT, CMD_STOP, CMD_STOP_ZERO:
                begin
                    follow_mode = 1'b0;
                    avoid_mode  = 1'b0;
                    act = (it.command_code == CMD_BACK)  ? ACT_BACK :
                          (it.command_code == CMD_LEFT)  ? ACT_LEFT :
                          (it.command_code == CMD_RIGHT) ? ACT_RIGHT : ACT_STOP;
                    if (it.command_code == CMD_STOP_ZERO)
                        spd = 0;
                end
                CMD_SET_SPEED:
                begin
                    spd = int'($signed(it.speed_value));
                    if (spd > int'(SPEED_MAX))
                        spd = int'(SPEED_MAX);
                    if (spd < int'(SPEED_MIN))
                        spd = int'(SPEED_MIN);
                end
                CMD_UP:   spd = spd + 1;
                CMD_DOWN: spd = spd - 1;
                CMD_FOLLOW:
                begin
                    if (!it.is_repeat)
                    begin
                        follow_mode = !follow_mode;
                        avoid_mode  = 1'b0;
                        phase_cur   = PHASE_NONE;
                        side_cur    = SIDE_UNKNOWN;
                        act         = ACT_STOP;
                    end
                end
                default: ;
            endcase
            if (spd == int'(SPEED_WRAP_HI) || spd == int'(SPEED_WRAP_LO))
                spd = 0;
            speed_cur = spd;
            fast_sel  = (spd > int'(cfg_cur.speed_switch));
        end
        else
        begin
            l = int'(it.left_range) / 100;
            r = int'(it.right_range) / 100;
            if (avoid_mode)
            begin
                thr = fast_sel ? int'(cfg_cur.avoid_fast_cm) : int'(cfg_cur.avoid_slow_cm);
                if (l < thr && r > thr)
                begin
                    heading_held = 1'b0;
                    act = ACT_RIGHT;
                end
                else if (l > thr && r < thr)
                begin
                    heading_held = 1'b0;
                    act = ACT_LEFT;
                end
                else if (l > thr && r > thr)
                begin
                    if (!heading_held)
                    begin
                        heading_held = 1'b1;
                        cap = 1'b1;
                    end
                    act = (speed_cur > 0) ? ACT_HOLD : ACT_NONE;
                end
                else if (l < thr && r < thr)
                begin
                    heading_held = 1'b0;
                    act = ACT_RIGHT;
                end
            end
            else if (follow_mode)
            begin
                n = int'(cfg_cur.follow_near_cm);
                f = int'(cfg_cur.follow_far_cm);
                // the action follows the phase held before this sample
                case (phase_cur)
                    PHASE_NONE, PHASE_NEAR:       act = ACT_STOP;
                    PHASE_FAR, PHASE_LOST_AHEAD:  act = ACT_FWD;
                    PHASE_LOST_LEFT:              act = ACT_LEFT;
                    PHASE_LOST_RIGHT:             act = ACT_RIGHT;
                    default:                      act = ACT_NONE;
                endcase
                if (act != ACT_NONE)
                begin
                    if (l < n && r > n)
                    begin
                        phase_cur = PHASE_NEAR;
                        side_cur  = SIDE_LEFT;
                    end
                    else if (l < n && r < n)
                    begin
                        phase_cur = PHASE_NEAR;
                        side_cur  = SIDE_AHEAD;
                    end
                    else if (l > n && r < n)
                    begin
                        phase_cur = PHASE_NEAR;
                        side_cur  = SIDE_RIGHT;
                    end
                    else if (l > n && l < f && r > f)
                    begin
                        phase_cur = PHASE_FAR;
                        side_cur  = SIDE_LEFT;
                    end
                    else if (l > n && l < f && r > n && r < f)
                    begin
                        phase_cur = PHASE_FAR;
                        side_cur  = SIDE_AHEAD;
                    end
                    else if (l > f && r > n && r < f)
                    begin
                        phase_cur = PHASE_FAR;
                        side_cur  = SIDE_RIGHT;
                    end
                    else if (l > f && r > f)
                    begin
                        // target gone: search toward the side it was last seen
                        if (phase_cur == PHASE_NONE)
                            side_cur = SIDE_UNKNOWN;
                        else if ((phase_cur == PHASE_NEAR || phase_cur == PHASE_FAR)
                                 && side_cur != SIDE_UNKNOWN)
                            phase_cur = {1'b0, side_cur} + 3'd2;
                    end
                end
            end
        end
        res.drive_action    = act;
        res.capture_heading = cap;
        res.speed_now       = speed_cur[7:0];
        res.mode_now        = avoid_mode ? MODE_AVOID : (follow_mode ? MODE_FOLLOW : MODE_NONE);
        res.follow_phase    = phase_cur;
        res.target_side     = side_cur;
        return res;
    endfunction

    // Pick a range in 1/100 cm: often within one centimetre of a threshold in
    // use, as often up to 90 cm, sometimes anywhere in the field or at an end.
    function automatic logic [15:0] pick_range();
        int sel;
        int base;
        int cm;
        int val;
        sel  = int'($urandom_range(0, 9));
        base = 0;
        if (sel == 0)
            return 16'($urandom_range(0, 65535));
        if (sel == 1)
            return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        if (sel <= 5)
        begin
            case (sel)
                2:       base = int'(cfg_cur.follow_near_cm);
                3:       base = int'(cfg_cur.follow_far_cm);
                4:       base = int'(cfg_cur.avoid_slow_cm);
                default: base = int'(cfg_cur.avoid_fast_cm);
            endcase
            cm = base + int'($urandom_range(0, 2)) - 1;
        end
        else
            cm = int'($urandom_range(0, 90));
        if (cm < 0)
            cm = 0;
        val = cm * 100 + int'($urandom_range(0, 99));
        if (val > 65535)
            val = 65535;
        return val[15:0];
    endfunction

    // Offer one item; return at the falling edge after it is taken.
    task automatic send_item(input item_t it, input logic pin, input result_t pin_res);
        int target;
        if (!quiet_tail && $urandom_range(0, 4) == 0)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.payload <= it;
        pinned_now      <= pin;
        pinned_result   <= pin_res;
        target = items_taken + 1;
        do
            @(negedge clk);
        while (items_taken < target);
    endtask

    // Write all five registers on consecutive cycles.
    task automatic write_cfg(input cfg_t c);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= REG_FOLLOW_NEAR;
        cfg_wr_data <= c.follow_near_cm;
        @(negedge clk);
        cfg_index   <= REG_FOLLOW_FAR;
        cfg_wr_data <= c.follow_far_cm;
        @(negedge clk);
        cfg_index   <= REG_AVOID_SLOW;
        cfg_wr_data <= c.avoid_slow_cm;
        @(negedge clk);
        cfg_index   <= REG_AVOID_FAST;
        cfg_wr_data <= c.avoid_fast_cm;
        @(negedge clk);
        cfg_index   <= REG_SPEED_SW;
        cfg_wr_data <= {1'b0, c.speed_switch};
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        cfg_cur = c;
    endtask

    // Hold until every predicted result has come back, then let the
    // pipeline settle.
    task automatic drain_results();
        while (expected_drive_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Predict on every accepted item; check every accepted result. Both
    // channels are sampled at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                predicted = next_drive_result(item_ch.payload);
                expected_drive_q.push_back(pinned_now ? pinned_result : predicted);
                items_taken++;
            end
            if (result_ch.valid && result_ch.ready)
            begin
                got = result_ch.payload;
                if (expected_drive_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result transaction: %p", got);
                end
                else
                begin
                    want = expected_drive_q.pop_front();
                    if (got.drive_action    !== want.drive_action    ||
                        got.capture_heading !== want.capture_heading ||
                        got.speed_now       !== want.speed_now       ||
                        got.mode_now        !== want.mode_now        ||
                        got.follow_phase    !== want.follow_phase    ||
                        got.target_side     !== want.target_side)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"result mismatch at %0t: expected act=%0d cap=%0d ",
                                      "speed=%0d mode=%0d phase=%0d side=%0d, got act=%0d ",
                                      "cap=%0d speed=%0d mode=%0d phase=%0d side=%0d"},
                                     $realtime, want.drive_action, want.capture_heading,
                                     want.speed_now, want.mode_now, want.follow_phase,
                                     want.target_side, got.drive_action,
                                     got.capture_heading, got.speed_now, got.mode_now,
                                     got.follow_phase, got.target_side);
                    end
                end
            end
        end
    end

    // Result side: stall in random bursts, never in the quiet tail.
    initial
    begin
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!quiet_tail && $urandom_range(0, 5) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
        end
    end

    // Stimulus and end of run.
    initial
    begin : stimulus
        item_t     it;
        stim_row_t row;
        result_t   pin_res;
        cfg_t      cfg_next;
        int        i;
        int        ph;
        int        sel;
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = REG_FOLLOW_NEAR;
        cfg_wr_data     = '0;
        item_ch.valid   = 1'b0;
        item_ch.payload = '0;
        pinned_now      = 1'b0;
        pinned_result   = '0;
        quiet_tail      = 1'b0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table under the reset thresholds.
        for (i = 0; i < DIR_N; i++)
        begin
            row = DIR_ROWS[i];
            it  = '{row.kind, row.l_range, row.r_range, row.code, row.sval, row.rep};
            pin_res = '{row.act, 1'b0, row.spd, row.mode, PHASE_NONE, SIDE_UNKNOWN};
            send_item(it, row.pin, pin_res);
        end
        item_ch.valid <= 1'b0;

        // Random phases. Each starts with the sender paused until every
        // result is back, so the registers change only while the block idles.
        for (ph = 0; ph < PHASES; ph++)
        begin
            drain_results();
            case (ph)
                0:       cfg_next = '{8'd0, 8'd0, 8'd0, 8'd0, 7'd0};
                1:       cfg_next = '{8'd255, 8'd255, 8'd255, 8'd255, 7'(SPEED_MAX)};
                default:
                begin
                    cfg_next.follow_near_cm = 8'($urandom_range(3, 40));
                    cfg_next.follow_far_cm  = 8'(cfg_next.follow_near_cm + $urandom_range(0, 60));
                    cfg_next.avoid_slow_cm  = 8'($urandom_range(3, 60));
                    cfg_next.avoid_fast_cm  = 8'($urandom_range(10, 120));
                    cfg_next.speed_switch   = 7'($urandom_range(0, 100));
                    // now and then a far limit drawn anywhere, possibly below the near one
                    if ($urandom_range(0, 3) == 0)
                        cfg_next.follow_far_cm = 8'($urandom_range(0, 255));
                end
            endcase
            write_cfg(cfg_next);
            if (ph == PHASES - 1)
                quiet_tail <= 1'b1;

            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                it.kind         = ($urandom_range(0, 99) < 30) ? KIND_COMMAND : KIND_SAMPLE;
                it.left_range   = pick_range();
                // equal pairs reach the both-near and both-far branches often
                it.right_range  = ($urandom_range(0, 3) == 0) ? it.left_range : pick_range();
                it.is_repeat    = ($urandom_range(0, 3) == 0);
                sel = int'($urandom_range(0, 99));
                if (sel < 16)      it.command_code = CMD_FWD;
                else if (sel < 28) it.command_code = CMD_FOLLOW;
                else if (sel < 40) it.command_code = CMD_SET_SPEED;
                else if (sel < 50) it.command_code = CMD_UP;
                else if (sel < 60) it.command_code = CMD_DOWN;
                else if (sel < 66) it.command_code = CMD_STOP_ZERO;
                else if (sel < 72) it.command_code = CMD_STOP;
                else if (sel < 78) it.command_code = CMD_BACK;
                else if (sel < 84) it.command_code = CMD_LEFT;
                else if (sel < 90) it.command_code = CMD_RIGHT;
                else it.command_code = 4'($urandom_range(CMD_FOLLOW + 1, CMD_UNKNOWN_TOP));
                // speeds at the limits and around the switch drive the wrap
                // and the threshold choice
                case ($urandom_range(0, 3))
                    0: it.speed_value = 8'($urandom_range(0, 255));
                    1: it.speed_value = ($urandom_range(0, 1) != 0) ? SPEED_MAX : SPEED_MIN;
                    2: it.speed_value = 8'(int'(cfg_cur.speed_switch)
                                           + int'($urandom_range(0, 2)) - 1);
                    default: it.speed_value = 8'(int'($urandom_range(0, 200)) - 100);
                endcase
                send_item(it, 1'b0, '0);
            end
            item_ch.valid <= 1'b0;
        end

        drain_results();
        repeat (16) @(negedge clk);
        if (mismatch_count == 0 && expected_drive_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
